>>> hdl/nicr_pkg.sv
// ----------------------------------------------------------------------------
// nicr_pkg
// Shared types and constants for the node id collision resolver: request and
// response structs, op and status codes, and the hash constants.
// ----------------------------------------------------------------------------
package nicr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned MAX_PROBES_DEF  = 1024;

  localparam logic [31:0] HASH_MUL_1     = 32'h7feb_352d;
  localparam logic [31:0] HASH_MUL_2     = 32'h846c_a68b;
  localparam logic [31:0] PROBE_STEP     = 32'h9e37_79b9;
  localparam logic [31:0] CAND_MASK      = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MUL_ADDR  = 32'd33;
  localparam logic [31:0] SEED_MUL_ID    = 32'd97;
  localparam logic [31:0] RESERVED_COUNT = 32'd4;
  localparam logic [31:0] BROADCAST_ID   = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DERIVED    = 3'd0,
    ST_FALLBACK   = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_TABLE_DONE = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] device_addr_low;
    logic [31:0] device_addr_high;
    logic [31:0] device_id_low;
    logic [31:0] device_id_high;
    logic [31:0] entry_node_id;
  } req_t;

  typedef struct packed {
    logic [31:0] node_id;
    logic [47:0] mac_address;
    status_e     status;
  } rsp_t;

endpackage

>>> hdl/node_id_collision_resolver_core.sv
// ----------------------------------------------------------------------------
// node_id_collision_resolver_core
// In-use node id table with clear, add and resolve requests. A resolve derives
// an id from the address words and, on a clash or a reserved id, probes hashed candidates.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload        direction
//  request   in_valid_i / in_ready_o   in_req_i       into block
//  response  out_valid_o / out_ready_i out_rsp_o      out of block
//
//  clear, add and unused op: response lands in the output register at once
//  resolve: each table scan reads the used entries in turn (one ram read port,
//    pipelined compare); a probe adds the PROBE state and a hash run (HASH1,
//    HASH2, HASH3) through the shared multiplier; the seed adds SEED_A and
//    SEED_B ahead of its own hash run
//  reset clears the fill count but not the table; table contents stay undefined
//    and only entries below the fill count are ever compared, so there is no clearing pass
//  a stalled response holds in the output register; a finished resolve waits
//    in its emit state until the register is free
// ----------------------------------------------------------------------------
module node_id_collision_resolver_core #(
  parameter int unsigned TABLE_DEPTH = nicr_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_PROBES  = nicr_pkg::MAX_PROBES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nicr_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output nicr_pkg::rsp_t out_rsp_o
);

  // widths derived from the parameters
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SEED_A,
    S_SEED_B,
    S_HASH1,
    S_HASH2,
    S_HASH3,
    S_PROBE,
    S_EMIT
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  logic [PW-1:0]      k_q;
  logic               rd_v_q;
  logic [31:0]        rd_q;
  logic               fb_q;        // probing hashed candidates
  logic               seed_ph_q;   // hash run produces the seed
  logic [31:0]        acc_q;       // shared unit accumulator
  logic [31:0]        step_q;      // seed + k * probe step
  logic [31:0]        cand_q;      // id under test
  logic [31:0]        derived_q;
  logic [31:0]        a0_q;
  logic [31:0]        a1_q;
  logic [31:0]        d0_q;
  logic [31:0]        d1_q;
  nicr_pkg::status_e  res_st_q;
  logic [31:0]        res_id_q;
  logic               out_valid_q;
  nicr_pkg::rsp_t     out_q;

  // in-use table, one write and one registered read port
  logic [31:0]        mem [TABLE_DEPTH];

  logic               out_free;
  logic               out_load;
  logic               in_acc;
  logic               wr_en;
  logic [31:0]        derived_raw;
  logic [31:0]        derived;
  logic               derived_rsv;
  logic               hit;
  logic               scan_end;
  logic [31:0]        mul_x;
  logic [31:0]        mul_y;
  logic [31:0]        mul_p;
  logic [31:0]        hash_out;
  logic [31:0]        cand_raw;
  logic [31:0]        cand_fix;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign in_acc      = in_valid_i && in_ready_o;
  assign wr_en       = in_acc && (in_req_i.op == nicr_pkg::OP_ADD)
                       && (count_q < CW'(TABLE_DEPTH));
  // a new response enters the output register this cycle
  assign out_load    = (in_acc && (in_req_i.op != nicr_pkg::OP_RESOLVE))
                       || ((state_q == S_EMIT) && out_free);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // derived id: byte swap of the address words, zero goes to one
  assign derived_raw = {in_req_i.device_addr_low[23:16], in_req_i.device_addr_low[31:24],
                        in_req_i.device_addr_high[7:0], in_req_i.device_addr_high[15:8]};
  assign derived     = (derived_raw == 32'd0) ? 32'd1 : derived_raw;
  assign derived_rsv = (derived < nicr_pkg::RESERVED_COUNT)
                       || (derived == nicr_pkg::BROADCAST_ID);

  // table scan: compare the entry read last cycle
  assign hit      = rd_v_q && (rd_q == cand_q);
  assign scan_end = (idx_q == count_q);

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    unique case (state_q)
      S_SEED_A: begin
        mul_x = a1_q;
        mul_y = nicr_pkg::SEED_MUL_ADDR;
      end
      S_SEED_B: begin
        mul_x = d1_q;
        mul_y = nicr_pkg::SEED_MUL_ID;
      end
      S_HASH1: begin
        mul_x = acc_q ^ (acc_q >> 16);
        mul_y = nicr_pkg::HASH_MUL_1;
      end
      S_HASH2: begin
        mul_x = acc_q ^ (acc_q >> 15);
        mul_y = nicr_pkg::HASH_MUL_2;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p    = mul_x * mul_y;
  assign hash_out = acc_q ^ (acc_q >> 16);

  // candidate: 31 bits, values below the reserved range raised past it;
  // after the mask the broadcast id cannot occur
  assign cand_raw = hash_out & nicr_pkg::CAND_MASK;
  assign cand_fix = (cand_raw < nicr_pkg::RESERVED_COUNT)
                    ? (cand_raw + nicr_pkg::RESERVED_COUNT) : cand_raw;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= in_req_i.entry_node_id;
    end
    rd_q <= mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      rd_v_q      <= 1'b0;
      fb_q        <= 1'b0;
      seed_ph_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            a0_q <= in_req_i.device_addr_low;
            a1_q <= in_req_i.device_addr_high;
            d0_q <= in_req_i.device_id_low;
            d1_q <= in_req_i.device_id_high;
            case (in_req_i.op)
              nicr_pkg::OP_RESOLVE: begin
                derived_q <= derived;
                cand_q    <= derived;
                idx_q     <= '0;
                rd_v_q    <= 1'b0;
                k_q       <= '0;
                fb_q      <= derived_rsv;
                state_q   <= derived_rsv ? S_SEED_A : S_SCAN;
              end
              default: begin
                out_valid_q       <= 1'b1;
                out_q.node_id     <= '0;
                out_q.mac_address <= '0;
                // an add that finds the table full is flagged
                out_q.status      <= (wr_en || (in_req_i.op != nicr_pkg::OP_ADD))
                                     ? nicr_pkg::ST_TABLE_DONE : nicr_pkg::ST_TABLE_FULL;
                if (in_req_i.op == nicr_pkg::OP_CLEAR) begin
                  count_q <= '0;
                end else if (wr_en) begin
                  count_q <= count_q + CW'(1);
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            rd_v_q <= 1'b0;
            if (!fb_q) begin
              // derived id in use, fall back to hashing
              fb_q    <= 1'b1;
              state_q <= S_SEED_A;
            end else if (k_q == PW'(MAX_PROBES - 1)) begin
              res_id_q <= derived_q;
              res_st_q <= nicr_pkg::ST_EXHAUSTED;
              state_q  <= S_EMIT;
            end else begin
              k_q     <= k_q + PW'(1);
              state_q <= S_PROBE;
            end
          end else if (scan_end) begin
            rd_v_q   <= 1'b0;
            res_id_q <= cand_q;
            res_st_q <= fb_q ? nicr_pkg::ST_FALLBACK : nicr_pkg::ST_DERIVED;
            state_q  <= S_EMIT;
          end else begin
            idx_q  <= idx_q + CW'(1);
            rd_v_q <= 1'b1;
          end
        end
        S_SEED_A: begin
          acc_q   <= mul_p;
          state_q <= S_SEED_B;
        end
        S_SEED_B: begin
          acc_q     <= acc_q ^ a0_q ^ d0_q ^ mul_p;
          seed_ph_q <= 1'b1;
          state_q   <= S_HASH1;
        end
        S_HASH1: begin
          acc_q   <= mul_p;
          state_q <= S_HASH2;
        end
        S_HASH2: begin
          acc_q   <= mul_p;
          state_q <= S_HASH3;
        end
        S_HASH3: begin
          if (seed_ph_q) begin
            // seed done, first probe uses seed itself
            step_q    <= hash_out;
            seed_ph_q <= 1'b0;
            state_q   <= S_PROBE;
          end else begin
            cand_q  <= cand_fix;
            idx_q   <= '0;
            rd_v_q  <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_PROBE: begin
          acc_q   <= step_q;
          step_q  <= step_q + nicr_pkg::PROBE_STEP;
          state_q <= S_HASH1;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q       <= 1'b1;
            out_q.node_id     <= res_id_q;
            out_q.mac_address <= {a1_q[15:0], a0_q};
            out_q.status      <= res_st_q;
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // fill count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // add to a full table answers table full on the next cycle
  a_full_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_req_i.op == nicr_pkg::OP_ADD) && (count_q == CW'(TABLE_DEPTH)))
    |=> (out_valid_o && (out_rsp_o.status == nicr_pkg::ST_TABLE_FULL)))
    else $error("full-table add not flagged");

  // fallback ids are 31-bit and clear of the reserved range
  a_fallback_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.status == nicr_pkg::ST_FALLBACK))
    |-> (!out_rsp_o.node_id[31] && (out_rsp_o.node_id >= nicr_pkg::RESERVED_COUNT)))
    else $error("fallback id out of range");
`endif

endmodule
